// ----- rtl/core/tft_pkg.sv -----
// shared constants and types for the trot foot trajectory block
package tft_pkg;

    localparam int DUTY_Q8 = 154;
    localparam int DUTY_C = (DUTY_Q8 < 52) ? 52 : ((DUTY_Q8 > 230) ? 230 : DUTY_Q8);
    localparam logic [31:0] PHASE_OFFSETS_Q8 = 32'd8421376;

    localparam int MIN_PERIOD_US = 100000;
    localparam int MRAD_Q8_TO_TURN_Q24 = 683566;

    localparam int SIN_A = 25736;
    localparam int SIN_B = 10512;
    localparam int SIN_C = 1160;
    localparam int SIN_LAT = 4;

    localparam int RST_GAIT_PERIOD = 500000;
    localparam int RST_SWING_HEIGHT = 500;
    localparam int RST_STEP_LENGTH = 800;
    localparam int RST_STEP_WIDTH = 400;
    localparam int RST_MAX_VEL_X = 500;
    localparam int RST_MAX_VEL_Y = 300;
    localparam int RST_MAX_YAW_RATE = 1000;
    localparam int RST_YAW_STEP = 200;

    typedef enum logic [2:0] {
        CFG_GAIT_PERIOD  = 3'd0,
        CFG_SWING_HEIGHT = 3'd1,
        CFG_STEP_LENGTH  = 3'd2,
        CFG_STEP_WIDTH   = 3'd3,
        CFG_MAX_VEL_X    = 3'd4,
        CFG_MAX_VEL_Y    = 3'd5,
        CFG_MAX_YAW_RATE = 3'd6,
        CFG_YAW_STEP     = 3'd7
    } cfg_index_t;

endpackage

// ----- rtl/core/trot_foot_trajectory.sv -----
// trot gait foot trajectory pipeline: one leg query in, one foot target out
//
//  channel   signals                         transaction when
//  item      item_valid / item_stall         valid high, stall low
//  result    result_valid / result_stall     valid high, stall low
//  config    cfg_write_en, cfg_index, data   write enable high
//
// one transaction per cycle while the result is not stalled; the pipeline depth is set by the
// 16-bit remainder divider and the 16-bit phase fraction divider in series.
// async active-low reset clears valids and config registers to defaults.
// a stalled result freezes the whole pipeline; item_stall follows it.
module trot_foot_trajectory
    import tft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         leg,
    input  logic [31:0]        elapsed_time_us,
    input  logic signed [15:0] nominal_x,
    input  logic signed [15:0] nominal_y,
    input  logic signed [15:0] nominal_z,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] yaw_rate,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] foot_x,
    output logic signed [15:0] foot_y,
    output logic signed [15:0] foot_z,
    output logic               in_swing,
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    localparam int QW_T  = 16;
    localparam int QW_XY = 26;
    localparam int QW_W  = 19;
    localparam int QW_F  = 16;

    localparam int S_R    = QW_T;
    localparam int S_OFF  = S_R + 1;
    localparam int S_N    = S_R + 2;
    localparam int S_SW   = S_R + 3;
    localparam int S_S16  = S_SW + QW_F;
    localparam int S_F    = S_S16 + 1;
    localparam int S_SINL = S_S16 + SIN_LAT;
    localparam int S_MUL  = S_SINL + 1;
    localparam int S_OUT  = S_MUL + 1;

    localparam int S_QXY  = 1 + QW_XY;
    localparam int S_QW   = 1 + QW_W;
    localparam int S_ANGM = S_QW + 1;
    localparam int S_ANG  = S_QW + 2;
    localparam int S_SC   = S_ANG + SIN_LAT;
    localparam int S_D    = S_SC + 2;
    localparam int S_SXT  = S_D + 1;

    // config registers
    logic [23:0] gait_period_reg;
    logic [10:0] swing_height_reg;
    logic [11:0] step_length_reg;
    logic [11:0] step_width_reg;
    logic [12:0] max_vel_x_reg;
    logic [12:0] max_vel_y_reg;
    logic [13:0] max_yaw_rate_reg;
    logic [10:0] yaw_step_reg;

    logic [23:0] period_eff;
    logic [31:0] cyc;
    logic [31:0] split_reg;

    logic adv;
    logic vld_reg [0:S_OUT];

    // item registers and delay lines
    logic [31:0]        t_reg;
    logic signed [15:0] vx_reg;
    logic signed [15:0] vy_reg;
    logic signed [15:0] wz_reg;
    logic [1:0]         leg_d [0:S_R];
    logic signed [15:0] x0_d [0:S_MUL];
    logic signed [15:0] y0_d [0:S_MUL];
    logic signed [15:0] z0_d [0:S_MUL];

    // phase path
    logic [23:0] r_rem;
    logic [7:0]  off;
    logic [31:0] r256_reg;
    logic [31:0] offt_reg;
    logic [32:0] nsum;
    logic [31:0] n_reg;
    logic        swing_now;
    logic [31:0] pnum_reg;
    logic [31:0] pden_reg;
    logic        swing_d [S_SW:S_MUL];
    logic [15:0] s16;
    logic signed [16:0] f_d [S_F:S_SINL];
    logic signed [15:0] sin_lift;
    logic signed [27:0] lift_reg;

    // step path
    logic [13:0] cm_x;
    logic [13:0] cm_y;
    logic [13:0] cm_w;
    logic [39:0] nx_reg;
    logic [39:0] ny_reg;
    logic [32:0] nw_reg;
    logic        negx_d [1:S_QXY];
    logic        zerox_d [1:S_QXY];
    logic        negy_d [1:S_QXY];
    logic        zeroy_d [1:S_QXY];
    logic        negw_d [1:S_ANGM];
    logic        zerow_d [1:S_QW];
    logic [25:0] qx;
    logic [25:0] qy;
    logic [18:0] qw;
    logic [18:0] yaw_mag;
    logic [38:0] ang_prod;
    logic [14:0] angm_reg;
    logic [15:0] ang;
    logic [15:0] ang_reg;
    logic [15:0] angc_reg;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
    logic signed [16:0] cm1;
    logic signed [32:0] p_cx_reg;
    logic signed [32:0] p_sy_reg;
    logic signed [32:0] p_sx_reg;
    logic signed [32:0] p_cy_reg;
    logic signed [33:0] dx_reg;
    logic signed [33:0] dy_reg;
    logic signed [26:0] sx_reg;
    logic signed [26:0] sy_reg;
    logic signed [34:0] sxt_d [S_SXT:S_SINL];
    logic signed [34:0] syt_d [S_SXT:S_SINL];
    logic signed [51:0] prodx_reg;
    logic signed [51:0] prody_reg;

    logic signed [15:0] foot_x_reg;
    logic signed [15:0] foot_y_reg;
    logic signed [15:0] foot_z_reg;
    logic               in_swing_reg;

    function automatic logic [13:0] clamp_mag(input logic signed [15:0] v,
                                              input logic [13:0] lim);
        logic [16:0] m;
        m = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
        return (m > {3'b000, lim}) ? lim : m[13:0];
    endfunction

    function automatic logic signed [15:0] round_sat(input logic signed [53:0] v);
        logic signed [53:0] w;
        logic signed [23:0] r;
        w = v + 54'sd536870912;
        r = w[53:30];
        if (r > 24'sd32767)
            return 16'sh7fff;
        else if (r < -24'sd32768)
            return 16'sh8000;
        else
            return r[15:0];
    endfunction

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gait_period_reg  <= 24'(RST_GAIT_PERIOD);
            swing_height_reg <= 11'(RST_SWING_HEIGHT);
            step_length_reg  <= 12'(RST_STEP_LENGTH);
            step_width_reg   <= 12'(RST_STEP_WIDTH);
            max_vel_x_reg    <= 13'(RST_MAX_VEL_X);
            max_vel_y_reg    <= 13'(RST_MAX_VEL_Y);
            max_yaw_rate_reg <= 14'(RST_MAX_YAW_RATE);
            yaw_step_reg     <= 11'(RST_YAW_STEP);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAIT_PERIOD:  gait_period_reg  <= cfg_data;
                CFG_SWING_HEIGHT: swing_height_reg <= cfg_data[10:0];
                CFG_STEP_LENGTH:  step_length_reg  <= cfg_data[11:0];
                CFG_STEP_WIDTH:   step_width_reg   <= cfg_data[11:0];
                CFG_MAX_VEL_X:    max_vel_x_reg    <= cfg_data[12:0];
                CFG_MAX_VEL_Y:    max_vel_y_reg    <= cfg_data[12:0];
                CFG_MAX_YAW_RATE: max_yaw_rate_reg <= cfg_data[13:0];
                CFG_YAW_STEP:     yaw_step_reg     <= cfg_data[10:0];
                default:          ;
            endcase
        end
    end

    assign period_eff = (gait_period_reg < 24'(MIN_PERIOD_US)) ? 24'(MIN_PERIOD_US)
                                                               : gait_period_reg;
    assign cyc = {period_eff, 8'h00};

    always_ff @(posedge clk)
    begin
        split_reg <= 32'(DUTY_C) * {8'h00, period_eff};
    end

    // pipeline control
    assign adv        = !vld_reg[S_OUT] || !result_stall;
    assign item_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= S_OUT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int k = 1; k <= S_OUT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 0 and delay lines
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg    <= elapsed_time_us;
            vx_reg   <= vel_x;
            vy_reg   <= vel_y;
            wz_reg   <= yaw_rate;
            leg_d[0] <= leg;
            x0_d[0]  <= nominal_x;
            y0_d[0]  <= nominal_y;
            z0_d[0]  <= nominal_z;
            for (int k = 1; k <= S_R; k++)
                leg_d[k] <= leg_d[k-1];
            for (int k = 1; k <= S_MUL; k++)
            begin
                x0_d[k] <= x0_d[k-1];
                y0_d[k] <= y0_d[k-1];
                z0_d[k] <= z0_d[k-1];
            end
        end
    end

    // phase: t mod period
    tft_div #(.NUM_W(32), .DEN_W(24), .QUO_W(QW_T)) u_div_t (
        .clk (clk),
        .en  (adv),
        .num (t_reg),
        .den (period_eff),
        .quo (),
        .rem (r_rem)
    );

    assign off       = PHASE_OFFSETS_Q8[{leg_d[S_R], 3'b000} +: 8];
    assign nsum      = {1'b0, r256_reg} + {1'b0, offt_reg};
    assign swing_now = n_reg >= split_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r256_reg <= {r_rem, 8'h00};
            offt_reg <= 32'(off) * {8'h00, period_eff};
            n_reg    <= (nsum >= {1'b0, cyc}) ? 32'(nsum - {1'b0, cyc}) : nsum[31:0];
            pnum_reg <= swing_now ? (n_reg - split_reg) : n_reg;
            pden_reg <= swing_now ? (cyc - split_reg) : split_reg;
            swing_d[S_SW] <= swing_now;
            for (int k = S_SW + 1; k <= S_MUL; k++)
                swing_d[k] <= swing_d[k-1];
        end
    end

    // phase fraction within stance or swing, q16
    tft_div #(.NUM_W(48), .DEN_W(32), .QUO_W(QW_F)) u_div_f (
        .clk (clk),
        .en  (adv),
        .num ({pnum_reg, 16'h0000}),
        .den (pden_reg),
        .quo (s16),
        .rem ()
    );

    tft_sin u_sin_lift (
        .clk   (clk),
        .en    (adv),
        .angle ({1'b0, s16[15:1]}),
        .sine  (sin_lift)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_d[S_F] <= swing_d[S_S16] ? ($signed({1'b0, s16}) - 17'sd32768)
                                       : (17'sd32768 - $signed({1'b0, s16}));
            for (int k = S_F + 1; k <= S_SINL; k++)
                f_d[k] <= f_d[k-1];
        end
    end

    // step vector: clamp and scale
    assign cm_x = clamp_mag(vx_reg, {1'b0, max_vel_x_reg});
    assign cm_y = clamp_mag(vy_reg, {1'b0, max_vel_y_reg});
    assign cm_w = clamp_mag(wz_reg, max_yaw_rate_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg <= {26'(cm_x) * 26'(step_length_reg), 14'h0000};
            ny_reg <= {26'(cm_y) * 26'(step_width_reg), 14'h0000};
            nw_reg <= {25'(cm_w) * 25'(yaw_step_reg), 8'h00};
            negx_d[1]  <= vx_reg[15];
            zerox_d[1] <= (max_vel_x_reg == 13'd0);
            negy_d[1]  <= vy_reg[15];
            zeroy_d[1] <= (max_vel_y_reg == 13'd0);
            negw_d[1]  <= wz_reg[15];
            zerow_d[1] <= (max_yaw_rate_reg == 14'd0);
            for (int k = 2; k <= S_QXY; k++)
            begin
                negx_d[k]  <= negx_d[k-1];
                zerox_d[k] <= zerox_d[k-1];
                negy_d[k]  <= negy_d[k-1];
                zeroy_d[k] <= zeroy_d[k-1];
            end
            for (int k = 2; k <= S_ANGM; k++)
                negw_d[k] <= negw_d[k-1];
            for (int k = 2; k <= S_QW; k++)
                zerow_d[k] <= zerow_d[k-1];
        end
    end

    tft_div #(.NUM_W(40), .DEN_W(13), .QUO_W(QW_XY)) u_div_x (
        .clk (clk),
        .en  (adv),
        .num (nx_reg),
        .den (max_vel_x_reg),
        .quo (qx),
        .rem ()
    );

    tft_div #(.NUM_W(40), .DEN_W(13), .QUO_W(QW_XY)) u_div_y (
        .clk (clk),
        .en  (adv),
        .num (ny_reg),
        .den (max_vel_y_reg),
        .quo (qy),
        .rem ()
    );

    tft_div #(.NUM_W(33), .DEN_W(14), .QUO_W(QW_W)) u_div_w (
        .clk (clk),
        .en  (adv),
        .num (nw_reg),
        .den (max_yaw_rate_reg),
        .quo (qw),
        .rem ()
    );

    // yaw angle in 1/65536 turn
    assign yaw_mag  = zerow_d[S_QW] ? 19'd0 : qw;
    assign ang_prod = 39'(yaw_mag) * 39'(MRAD_Q8_TO_TURN_Q24);
    assign ang      = negw_d[S_ANGM] ? (16'd0 - {1'b0, angm_reg}) : {1'b0, angm_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            angm_reg <= ang_prod[38:24];
            ang_reg  <= ang;
            angc_reg <= ang + 16'd16384;
        end
    end

    tft_sin u_sin_yaw (
        .clk   (clk),
        .en    (adv),
        .angle (ang_reg),
        .sine  (sn)
    );

    tft_sin u_cos_yaw (
        .clk   (clk),
        .en    (adv),
        .angle (angc_reg),
        .sine  (cs)
    );

    // yaw displacement and step totals
    assign cm1 = 17'(cs) - 17'sd16384;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_cx_reg <= cm1 * x0_d[S_SC];
            p_sy_reg <= sn * y0_d[S_SC];
            p_sx_reg <= sn * x0_d[S_SC];
            p_cy_reg <= cm1 * y0_d[S_SC];
            dx_reg   <= 34'(p_cx_reg) - 34'(p_sy_reg);
            dy_reg   <= 34'(p_sx_reg) + 34'(p_cy_reg);
            sx_reg   <= zerox_d[S_QXY] ? 27'sd0
                        : (negx_d[S_QXY] ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
            sy_reg   <= zeroy_d[S_QXY] ? 27'sd0
                        : (negy_d[S_QXY] ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));
            sxt_d[S_SXT] <= 35'(sx_reg) + 35'(dx_reg);
            syt_d[S_SXT] <= 35'(sy_reg) + 35'(dy_reg);
            for (int k = S_SXT + 1; k <= S_SINL; k++)
            begin
                sxt_d[k] <= sxt_d[k-1];
                syt_d[k] <= syt_d[k-1];
            end
        end
    end

    // final products, rounding and output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prodx_reg <= sxt_d[S_SINL] * f_d[S_SINL];
            prody_reg <= syt_d[S_SINL] * f_d[S_SINL];
            lift_reg  <= swing_d[S_SINL] ? ($signed({1'b0, swing_height_reg}) * sin_lift)
                                         : 28'sd0;
            foot_x_reg   <= round_sat((54'(x0_d[S_MUL]) <<< 30) + 54'(prodx_reg));
            foot_y_reg   <= round_sat((54'(y0_d[S_MUL]) <<< 30) + 54'(prody_reg));
            foot_z_reg   <= round_sat((54'(z0_d[S_MUL]) <<< 30) + (54'(lift_reg) <<< 16));
            in_swing_reg <= swing_d[S_MUL];
        end
    end

    assign result_valid = vld_reg[S_OUT];
    assign foot_x       = foot_x_reg;
    assign foot_y       = foot_y_reg;
    assign foot_z       = foot_z_reg;
    assign in_swing     = in_swing_reg;

endmodule

// ----- rtl/core/tft_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module tft_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 24,
    parameter int QUO_W = 16
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [W-1:0]     rem_reg [0:QUO_W-1];
    logic [QUO_W-1:0] quo_reg [0:QUO_W-1];
    logic [DEN_W-1:0] den_reg [0:QUO_W-1];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_step
            localparam int B = QUO_W - 1 - k;
            logic [W-1:0]     rem_in;
            logic [QUO_W-1:0] quo_in;
            logic [DEN_W-1:0] den_in;
            logic [W-1:0]     den_sh;
            logic             fits;

            if (k == 0)
            begin : g_first
                assign rem_in = W'(num);
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            assign den_sh = W'(den_in) << B;
            assign fits   = (rem_in >> B) >= W'(den_in);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= fits ? (rem_in - den_sh) : rem_in;
                    quo_reg[k] <= quo_in | (QUO_W'(fits) << B);
                    den_reg[k] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QUO_W-1];
    assign rem = rem_reg[QUO_W-1][DEN_W-1:0];

endmodule

// ----- rtl/core/tft_sin.sv -----
// four-stage quarter-wave polynomial sine, q14 output
module tft_sin
    import tft_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [15:0] sine
);

    logic [13:0] fr;
    logic [14:0] x1;
    logic [29:0] xx1;

    logic [14:0] x_reg1;
    logic [14:0] x2_reg1;
    logic        neg_reg1;

    logic [25:0] cx2;
    logic [13:0] t2;
    logic [14:0] x_reg2;
    logic [14:0] x2_reg2;
    logic [13:0] t2_reg2;
    logic        neg_reg2;

    logic [28:0] tx3;
    logic [14:0] t4;
    logic [14:0] x_reg3;
    logic [14:0] t4_reg3;
    logic        neg_reg3;

    logic [29:0] xt4;
    logic [15:0] y4;
    logic signed [15:0] sine_reg;

    assign fr  = angle[13:0];
    assign x1  = angle[14] ? (15'd16384 - {1'b0, fr}) : {1'b0, fr};
    assign xx1 = 30'(x1) * 30'(x1);

    assign cx2 = 26'(SIN_C) * 26'(x2_reg1);
    assign t2  = 14'(SIN_B) - {2'b00, cx2[25:14]};

    assign tx3 = 29'(t2_reg2) * 29'(x2_reg2);
    assign t4  = 15'(SIN_A) - tx3[28:14];

    assign xt4 = 30'(x_reg3) * 30'(t4_reg3);
    assign y4  = xt4[29:14];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg1   <= x1;
            x2_reg1  <= xx1[28:14];
            neg_reg1 <= angle[15];

            x_reg2   <= x_reg1;
            x2_reg2  <= x2_reg1;
            t2_reg2  <= t2;
            neg_reg2 <= neg_reg1;

            x_reg3   <= x_reg2;
            t4_reg3  <= t4;
            neg_reg3 <= neg_reg2;

            sine_reg <= neg_reg3 ? -$signed(y4) : $signed(y4);
        end
    end

    assign sine = sine_reg;

endmodule

// ----- tb/trot_foot_trajectory_checker.sv -----
// checker for trot_foot_trajectory: predicts foot targets and compares results
`timescale 1ns / 1ps
module trot_foot_trajectory_checker
    import tft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  logic [1:0]         leg,
    input  logic [31:0]        elapsed_time_us,
    input  logic signed [15:0] nominal_x,
    input  logic signed [15:0] nominal_y,
    input  logic signed [15:0] nominal_z,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] yaw_rate,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic signed [15:0] foot_x,
    input  logic signed [15:0] foot_y,
    input  logic signed [15:0] foot_z,
    input  logic               in_swing,
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic               sw;
    } foot_t;

    foot_t foot_q[$];

    logic [23:0] r_period;
    logic [10:0] r_height;
    logic [11:0] r_len;
    logic [11:0] r_wid;
    logic [12:0] r_vx;
    logic [12:0] r_vy;
    logic [13:0] r_wz;
    logic [10:0] r_yaw;

    function automatic longint sine_q14(logic [31:0] u);
        longint unsigned q, f, x, x2, t, y;
        begin
            q = (u >> 14) & 3;
            f = u & 32'h3FFF;
            x = q[0] ? (16384 - f) : f;
            x2 = (x * x) >> 14;
            t = (SIN_C * x2) >> 14;
            t = SIN_B - t;
            t = (t * x2) >> 14;
            t = SIN_A - t;
            y = (x * t) >> 14;
            return q[1] ? -longint'(y) : longint'(y);
        end
    endfunction

    function automatic longint step_scale(longint v, longint lim, longint scale, longint mult);
        longint c;
        begin
            if (lim == 0) return 0;
            c = (v > lim) ? lim : ((v < -lim) ? -lim : v);
            return c * scale * mult / lim;
        end
    endfunction

    function automatic logic signed [15:0] round_sat16(longint v);
        longint r;
        begin
            v += longint'(1) << 29;
            if (v >= 0) r = v >>> 30;
            else r = -((-v + (longint'(1) << 30) - 1) >>> 30);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[15:0];
        end
    endfunction

    function automatic foot_t foot_target(logic [1:0] lg, logic [31:0] t,
            longint x0, longint y0, longint z0, longint vx, longint vy, longint wz);
        longint unsigned per, off, cyc, n, split, num, den, s16, mag, ang;
        longint sx, sy, yw, sn, cm1, f, lift;
        logic sw;
        foot_t o;
        begin
            per = (r_period < MIN_PERIOD_US) ? MIN_PERIOD_US : r_period;
            off = (PHASE_OFFSETS_Q8 >> (8 * lg)) & 8'hFF;
            cyc = 256 * per;
            n = ((t % per) * 256 + off * per) % cyc;
            split = DUTY_C * per;
            sw = !(n < split);
            num = sw ? n - split : n;
            den = sw ? cyc - split : split;
            s16 = (num * 65536) / den;
            sx = step_scale(vx, r_vx, r_len, 16384);
            sy = step_scale(vy, r_vy, r_wid, 16384);
            yw = step_scale(wz, r_wz, r_yaw, 256);
            mag = (yw < 0) ? -yw : yw;
            ang = (mag * MRAD_Q8_TO_TURN_Q24) >> 24;
            if (yw < 0) ang = -ang;
            sn = sine_q14(ang[31:0]);
            cm1 = sine_q14(ang[31:0] + 32'd16384) - 16384;
            sx += cm1 * x0 - sn * y0;
            sy += sn * x0 + cm1 * y0;
            f = sw ? longint'(s16) - 32768 : 32768 - longint'(s16);
            lift = sw ? longint'(r_height) * sine_q14(32'(s16 >> 1)) : 0;
            o.fx = round_sat16(x0 * (longint'(1) << 30) + sx * f);
            o.fy = round_sat16(y0 * (longint'(1) << 30) + sy * f);
            o.fz = round_sat16(z0 * (longint'(1) << 30) + lift * 65536);
            o.sw = sw;
            return o;
        end
    endfunction

    assign pending = foot_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        foot_t e;
        if (!rst_n)
        begin
            r_period = 24'(RST_GAIT_PERIOD);
            r_height = 11'(RST_SWING_HEIGHT);
            r_len = 12'(RST_STEP_LENGTH);
            r_wid = 12'(RST_STEP_WIDTH);
            r_vx = 13'(RST_MAX_VEL_X);
            r_vy = 13'(RST_MAX_VEL_Y);
            r_wz = 14'(RST_MAX_YAW_RATE);
            r_yaw = 11'(RST_YAW_STEP);
            errors = 0;
            foot_q.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (foot_q.size() == 0)
                begin
                    $display("%0t unexpected result x=%0d y=%0d z=%0d swing=%0b",
                             $time, foot_x, foot_y, foot_z, in_swing);
                    errors++;
                end
                else
                begin
                    e = foot_q.pop_front();
                    if (e.fx !== foot_x || e.fy !== foot_y || e.fz !== foot_z
                            || e.sw !== in_swing)
                    begin
                        $display("%0t mismatch expected x=%0d y=%0d z=%0d swing=%0b",
                                 $time, e.fx, e.fy, e.fz, e.sw);
                        $display("%0t          actual   x=%0d y=%0d z=%0d swing=%0b",
                                 $time, foot_x, foot_y, foot_z, in_swing);
                        errors++;
                    end
                end
            end
            if (item_valid && !item_stall)
                foot_q.push_back(foot_target(leg, elapsed_time_us, nominal_x, nominal_y,
                                             nominal_z, vel_x, vel_y, yaw_rate));
            if (cfg_write_en)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_GAIT_PERIOD:  r_period = cfg_data;
                    CFG_SWING_HEIGHT: r_height = cfg_data[10:0];
                    CFG_STEP_LENGTH:  r_len = cfg_data[11:0];
                    CFG_STEP_WIDTH:   r_wid = cfg_data[11:0];
                    CFG_MAX_VEL_X:    r_vx = cfg_data[12:0];
                    CFG_MAX_VEL_Y:    r_vy = cfg_data[12:0];
                    CFG_MAX_YAW_RATE: r_wz = cfg_data[13:0];
                    CFG_YAW_STEP:     r_yaw = cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- tb/trot_foot_trajectory_test.sv -----
// testbench top for trot_foot_trajectory: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module trot_foot_trajectory_test;
    import tft_pkg::*;

    localparam int LATENCY = 42;
    localparam longint LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [1:0] leg = '0;
    logic [31:0] elapsed_time_us = '0;
    logic signed [15:0] nominal_x = '0, nominal_y = '0, nominal_z = '0;
    logic signed [15:0] vel_x = '0, vel_y = '0, yaw_rate = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [15:0] foot_x, foot_y, foot_z;
    logic in_swing;
    logic cfg_write_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;
    int errors, pending;
    longint cycles = 0;
    bit calm = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    trot_foot_trajectory u_top (.*);

    trot_foot_trajectory_checker u_check (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[trot_foot_trajectory] ERROR");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 7);
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 600)) - 300);
            3: return 16'(int'($urandom_range(0, 12000)) - 6000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_leg(logic [1:0] l, logic [31:0] t, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z, logic [15:0] vx, logic [15:0] vy,
                            logic [15:0] wz);
        int n;
        begin
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 7);
                item_valid <= 1'b0;
                repeat (n) @(posedge clk);
            end
            item_valid <= 1'b1;
            leg <= l;
            elapsed_time_us <= t;
            nominal_x <= x;
            nominal_y <= y;
            nominal_z <= z;
            vel_x <= vx;
            vel_y <= vy;
            yaw_rate <= wz;
            @(posedge clk);
            while (item_stall) @(posedge clk);
        end
    endtask

    task automatic send_random();
        send_leg(2'($urandom), $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000000),
                 pick16(), pick16(), pick16(), pick16(), pick16(), pick16());
    endtask

    task automatic drain();
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
            repeat (LATENCY + 4) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] v);
        begin
            cfg_write_en <= 1'b1;
            cfg_index <= idx;
            cfg_data <= v;
            @(posedge clk);
            cfg_write_en <= 1'b0;
        end
    endtask

    task automatic write_all(logic [23:0] p, logic [23:0] h, logic [23:0] sl,
                             logic [23:0] sw, logic [23:0] vx, logic [23:0] vy,
                             logic [23:0] wz, logic [23:0] ys);
        begin
            write_reg(CFG_GAIT_PERIOD, p);
            write_reg(CFG_SWING_HEIGHT, h);
            write_reg(CFG_STEP_LENGTH, sl);
            write_reg(CFG_STEP_WIDTH, sw);
            write_reg(CFG_MAX_VEL_X, vx);
            write_reg(CFG_MAX_VEL_Y, vy);
            write_reg(CFG_MAX_YAW_RATE, wz);
            write_reg(CFG_YAW_STEP, ys);
        end
    endtask

    initial
    begin
        int ph;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of every field under reset settings
        send_leg(0, 0, 0, 0, 0, 0, 0, 0);
        send_leg(1, 32'hFFFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_leg(2, 123456, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_leg(3, 384999, 1000, -1000, -2000, 500, -300, 1000);
        send_leg(0, 385000, 1000, -1000, -2000, -500, 300, -1000);
        send_leg(1, 499999, -20, 30, 16'h7FF0, 600, -600, -2000);
        send_leg(2, 442500, 3000, 2000, 0, 12, 34, 56);
        send_leg(3, 250000, 0, 0, -32000, -40, 0, 0);
        drain();
        // pressure: sender holds each item until it is taken; drain waits for everything outstanding
        // zero limits, short period, swing height 2000
        write_all(24'd50, 2000, 3000, 3000, 0, 0, 0, 1571);
        for (int i = 0; i < 8; i++) send_random();
        send_leg(0, 99999, 100, 100, 100, 16'h7FFF, 16'h8000, 16'h7FFF);
        drain();
        write_all(24'hFFFFFF, 0, 0, 0, 5000, 5000, 10000, 0);
        for (int i = 0; i < 6; i++) send_random();
        drain();

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_all(24'(RST_GAIT_PERIOD), 24'(RST_SWING_HEIGHT),
                             24'(RST_STEP_LENGTH), 24'(RST_STEP_WIDTH),
                             24'(RST_MAX_VEL_X), 24'(RST_MAX_VEL_Y),
                             24'(RST_MAX_YAW_RATE), 24'(RST_YAW_STEP));
                1: write_all(100000, 2000, 3000, 3000, 1, 1, 1, 1571);
                2: write_all(10000000, 1000, 1500, 1500, 5000, 5000, 10000, 800);
                default: write_all(24'($urandom), 24'($urandom_range(0, 2047)),
                                   24'($urandom_range(0, 4095)),
                                   24'($urandom_range(0, 4095)),
                                   24'($urandom_range(0, 8191)),
                                   24'($urandom_range(0, 8191)),
                                   24'($urandom_range(0, 16383)),
                                   24'($urandom_range(0, 2047)));
            endcase
            if (ph == 4) calm = 1;
            for (int i = 0; i < 320; i++) send_random();
            drain();
        end

        if (errors == 0)
            $display("[trot_foot_trajectory] OK");
        else
            $display("[trot_foot_trajectory] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tft_pkg.sv
rtl/core/tft_div.sv
rtl/core/tft_sin.sv
rtl/core/trot_foot_trajectory.sv
tb/trot_foot_trajectory_checker.sv
tb/trot_foot_trajectory_test.sv
